FILE: rtl/pcbs_pkg.sv
// shared types, constants and the detection record for per-class box suppression
package pcbs_pkg;

  localparam int MAX_BOXES     = 64;
  localparam int CLASS_COUNT   = 20;
  localparam int IDX_W         = $clog2(MAX_BOXES);
  localparam int CNT_W         = $clog2(MAX_BOXES + 1);
  localparam logic [15:0] THR_RESET = 16'd29491;
  localparam int IOU_LAT       = 5;

  // input request
  typedef struct packed {
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [15:0] box_w;
    logic [15:0] box_h;
    logic [15:0] score;
    logic [15:0] obj_prob;
    logic [4:0]  obj_class;
    logic        last_in;
  } in_t;

  // result request
  typedef struct packed {
    logic [15:0] kept_x;
    logic [15:0] kept_y;
    logic [15:0] kept_w;
    logic [15:0] kept_h;
    logic [15:0] kept_score;
    logic [15:0] kept_prob;
    logic [4:0]  kept_class;
    logic        last_out;
    logic        overflowed;
  } out_t;

  // stored detection
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic [15:0] prob;
    logic [4:0]  cls;
  } det_t;

  // controller to datapath commands
  typedef struct packed {
    logic             mem_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_wr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_src_cur;
    logic             cur_load;
    logic             a_load;
    logic             keep_init;
    logic             keep_clr;
    logic             iou_start;
    logic             out_load;
    logic             out_last;
    logic             out_drop;
    logic [IDX_W-1:0] i_idx;
    logic [IDX_W-1:0] j_idx;
    logic [CNT_W-1:0] n_stored;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic score_gt;
    logic cls_eq;
    logic keep_i;
    logic keep_j;
    logic iou_done;
    logic iou_hit;
    logic out_free;
    logic more_kept;
  } sts_t;

endpackage

FILE: rtl/pcbs_iou.sv
// pipelined exact fixed-point iou threshold test, five stages
module pcbs_iou import pcbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  det_t        box_a,
  input  det_t        box_b,
  input  logic [15:0] thr,
  output logic        done,
  output logic        hit
);

  logic [IOU_LAT-1:0] v_r;
  logic [16:0] iw_r, ih_r;
  logic [31:0] wa_r, wb_r;
  logic [33:0] inter2_r, inter3_r, inter4_r;
  logic [34:0] asum_r, uni_r;
  logic        nz4_r;
  logic [33:0] plo_r;
  logic [32:0] phi_r;
  logic        hit_r;
  logic [16:0] iw_c, ih_c;

  // clamped overlap of two doubled-coordinate spans
  function automatic logic [16:0] overlap(input logic [15:0] ca, input logic [15:0] sa,
                                          input logic [15:0] cb, input logic [15:0] sb);
    logic signed [19:0] lo_a, hi_a, lo_b, hi_b, lo, hi, d;
    lo_a = $signed({3'b000, ca, 1'b0}) - $signed({4'b0000, sa});
    hi_a = $signed({3'b000, ca, 1'b0}) + $signed({4'b0000, sa});
    lo_b = $signed({3'b000, cb, 1'b0}) - $signed({4'b0000, sb});
    hi_b = $signed({3'b000, cb, 1'b0}) + $signed({4'b0000, sb});
    lo = (lo_a > lo_b) ? lo_a : lo_b;
    hi = (hi_a < hi_b) ? hi_a : hi_b;
    d  = hi - lo;
    return (d > 20'sd0) ? d[16:0] : 17'd0;
  endfunction

  assign iw_c = overlap(box_a.x, box_a.w, box_b.x, box_b.w);
  assign ih_c = overlap(box_a.y, box_a.h, box_b.y, box_b.h);

  // stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[IOU_LAT-2:0], start};
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    iw_r     <= iw_c;
    ih_r     <= ih_c;
    wa_r     <= box_a.w * box_a.h;
    wb_r     <= box_b.w * box_b.h;
    inter2_r <= iw_r * ih_r;
    asum_r   <= {1'b0, wa_r, 2'b00} + {1'b0, wb_r, 2'b00};
    uni_r    <= asum_r - {1'b0, inter2_r};
    inter3_r <= inter2_r;
    plo_r    <= thr * uni_r[17:0];
    phi_r    <= thr * uni_r[34:18];
    nz4_r    <= (uni_r != '0);
    inter4_r <= inter3_r;
    hit_r    <= nz4_r &&
                ({2'b00, inter4_r, 16'd0} > ({phi_r, 18'd0} + {17'd0, plo_r}));
  end

  assign done = v_r[IOU_LAT-1];
  assign hit  = hit_r;

endmodule

FILE: rtl/pcbs_datapath.sv
// detection store, working registers, keep flags, iou unit and output register
module pcbs_datapath import pcbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  in_t         in_data,
  input  logic        cfg_valid,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data
);

  det_t mem [MAX_BOXES];
  det_t rdata_r, cur_r, a_r, wdata;
  logic [MAX_BOXES-1:0] keep_r;
  logic [15:0] thr_r;
  logic        out_valid_r;
  out_t        out_r;
  logic        iou_done, iou_hit, above;

  // write data select
  always_comb begin
    wdata.x     = in_data.box_x;
    wdata.y     = in_data.box_y;
    wdata.w     = in_data.box_w;
    wdata.h     = in_data.box_h;
    wdata.score = in_data.score;
    wdata.prob  = in_data.obj_prob;
    wdata.cls   = in_data.obj_class;
    if (cmd.wr_src_cur) begin
      wdata = cur_r;
    end
  end

  // store, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[cmd.wr_addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[cmd.rd_addr];
    end
  end

  // working boxes
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      cur_r <= rdata_r;
    end
    if (cmd.a_load) begin
      a_r <= rdata_r;
    end
  end

  // keep flags
  always_ff @(posedge clk) begin
    if (cmd.keep_init) begin
      keep_r <= '1;
    end else if (cmd.keep_clr) begin
      keep_r[cmd.j_idx] <= 1'b0;
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  pcbs_iou u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.iou_start),
    .box_a (a_r),
    .box_b (rdata_r),
    .thr   (thr_r),
    .done  (iou_done),
    .hit   (iou_hit)
  );

  // any kept stored entry above index i
  always_comb begin
    above = 1'b0;
    for (int k = 0; k < MAX_BOXES; k++) begin
      if (k > int'(cmd.i_idx) && k < int'(cmd.n_stored)) begin
        above = above | keep_r[k];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.kept_x     <= rdata_r.x;
      out_r.kept_y     <= rdata_r.y;
      out_r.kept_w     <= rdata_r.w;
      out_r.kept_h     <= rdata_r.h;
      out_r.kept_score <= rdata_r.score;
      out_r.kept_prob  <= rdata_r.prob;
      out_r.kept_class <= rdata_r.cls;
      out_r.last_out   <= cmd.out_last;
      out_r.overflowed <= cmd.out_drop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status
  assign sts.score_gt  = rdata_r.score > cur_r.score;
  assign sts.cls_eq    = rdata_r.cls == a_r.cls;
  assign sts.keep_i    = keep_r[cmd.i_idx];
  assign sts.keep_j    = keep_r[cmd.j_idx];
  assign sts.iou_done  = iou_done;
  assign sts.iou_hit   = iou_hit;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.more_kept = above;

endmodule

FILE: rtl/pcbs_ctrl.sv
// sequencer for load, exchange sort, suppression and emission
module pcbs_ctrl import pcbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [13:0] {
    IDLE   = 14'b00000000000001,
    S_SI   = 14'b00000000000010,
    S_LD   = 14'b00000000000100,
    S_JRD  = 14'b00000000001000,
    S_CMP  = 14'b00000000010000,
    S_WB   = 14'b00000000100000,
    P_I    = 14'b00000001000000,
    P_LD   = 14'b00000010000000,
    P_J    = 14'b00000100000000,
    P_CHK  = 14'b00001000000000,
    P_WAIT = 14'b00010000000000,
    E_I    = 14'b00100000000000,
    E_OUT  = 14'b01000000000000,
    E_SPARE = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic drop_r, drop_nxt;
  logic [CNT_W-1:0] i_inc, j_inc;

  assign i_inc = i_r + 1'b1;
  assign j_inc = j_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      cnt_r   <= '0;
      drop_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    in_ready  = 1'b0;
    cmd             = '0;
    cmd.i_idx       = i_r[IDX_W-1:0];
    cmd.j_idx       = j_r[IDX_W-1:0];
    cmd.rd_addr     = i_r[IDX_W-1:0];
    cmd.wr_addr     = i_r[IDX_W-1:0];
    cmd.out_drop    = drop_r;
    cmd.n_stored    = cnt_r;
    unique case (state_r)
      IDLE: begin
        in_ready    = 1'b1;
        cmd.wr_addr = cnt_r[IDX_W-1:0];
        if (in_valid) begin
          if (cnt_r < CNT_W'(MAX_BOXES)) begin
            cmd.mem_wr = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = '0;
            state_nxt = S_SI;
          end
        end
      end
      // sort: hold entry i, sweep later entries
      S_SI: begin
        if (i_inc >= cnt_r) begin
          cmd.keep_init = 1'b1;
          i_nxt         = '0;
          state_nxt     = P_I;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_LD;
        end
      end
      S_LD: begin
        cmd.cur_load = 1'b1;
        j_nxt        = i_inc;
        state_nxt    = S_JRD;
      end
      S_JRD: begin
        cmd.rd_addr = j_r[IDX_W-1:0];
        if (j_r == cnt_r) begin
          state_nxt = S_WB;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.wr_addr    = j_r[IDX_W-1:0];
        cmd.wr_src_cur = 1'b1;
        if (sts.score_gt) begin
          cmd.mem_wr   = 1'b1;
          cmd.cur_load = 1'b1;
        end
        j_nxt     = j_inc;
        state_nxt = S_JRD;
      end
      S_WB: begin
        cmd.mem_wr     = 1'b1;
        cmd.wr_src_cur = 1'b1;
        i_nxt          = i_inc;
        state_nxt      = S_SI;
      end
      // suppression
      P_I: begin
        if (i_r == cnt_r) begin
          i_nxt     = '0;
          state_nxt = E_I;
        end else if (!sts.keep_i) begin
          i_nxt = i_inc;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = P_LD;
        end
      end
      P_LD: begin
        cmd.a_load = 1'b1;
        j_nxt      = i_inc;
        state_nxt  = P_J;
      end
      P_J: begin
        cmd.rd_addr = j_r[IDX_W-1:0];
        if (j_r == cnt_r) begin
          i_nxt     = i_inc;
          state_nxt = P_I;
        end else if (!sts.keep_j) begin
          j_nxt = j_inc;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = P_CHK;
        end
      end
      P_CHK: begin
        if (sts.cls_eq) begin
          cmd.iou_start = 1'b1;
          state_nxt     = P_WAIT;
        end else begin
          j_nxt     = j_inc;
          state_nxt = P_J;
        end
      end
      P_WAIT: begin
        if (sts.iou_done) begin
          cmd.keep_clr = sts.iou_hit;
          j_nxt        = j_inc;
          state_nxt    = P_J;
        end
      end
      // emission of kept entries
      E_I: begin
        if (i_r == cnt_r) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = IDLE;
        end else if (!sts.keep_i) begin
          i_nxt = i_inc;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = E_OUT;
        end
      end
      E_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = !sts.more_kept;
          i_nxt        = i_inc;
          state_nxt    = E_I;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/per_class_box_suppression.sv
// top level of per-class non-maximum suppression with exact iou
// Usage:
//   in_valid/in_ready/in_data carry one detection per request. A request
//   with last_in set closes the set and starts the work; in_ready is low
//   until every kept box of that set has been handed to the output register.
//   Up to MAX_BOXES detections are stored; further ones are dropped and the
//   set's results carry overflowed.
//   out_valid/out_ready/out_data deliver kept boxes in falling score order;
//   the last one carries last_out. A set with nothing kept gives no results.
//   cfg_valid/cfg_data write the iou threshold (Q0.16); cfg_ready is always
//   high, and writes are expected only while the block is idle.
// Sequence: a detection is written to the store as it is accepted. After
//   the last one, the exchange sort runs over the stored boxes through the
//   one store read port, suppression tests each same-class pair of kept
//   entries in the five-stage iou pipeline and skips other pairs, and
//   emission hands each kept entry to the output register in order.
// Reset: synchronous rst_n clears the set and the output, threshold 29491.
// A stalled receiver holds out_data; the sequencer waits at the output.
module per_class_box_suppression import pcbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  pcbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_in),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcbs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // output register is only loaded when free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output loaded while occupied");

  // store write and read never hit the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mem_wr && cmd.mem_rd) |-> (cmd.wr_addr != cmd.rd_addr))
    else $error("store read and write collide");

  // iou result follows its start by the pipeline depth
  a_iou_lat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iou_start |-> ##IOU_LAT sts.iou_done)
    else $error("iou result missing");

endmodule

FILE: test/per_class_box_suppression_tb.sv
// testbench for per-class box suppression: directed and random detection sets against a predictor
`timescale 1ns / 1ps

module per_class_box_suppression_tb;
  import pcbs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  per_class_box_suppression dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  det_t        set_boxes[$];
  logic        set_dropped;
  logic [15:0] iou_thr;
  out_t        kept_queue[$];
  int          mismatch_count;
  bit          idle_on;

  // clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // clamped overlap of two spans in doubled coordinates
  function automatic longint span_overlap(longint ca, longint sa, longint cb, longint sb);
    longint lo, hi;
    lo = (2 * ca - sa > 2 * cb - sb) ? 2 * ca - sa : 2 * cb - sb;
    hi = (2 * ca + sa < 2 * cb + sb) ? 2 * ca + sa : 2 * cb + sb;
    return (hi - lo > 0) ? hi - lo : 0;
  endfunction

  // exact iou test in doubled coordinates
  function automatic bit iou_above(det_t a, det_t b);
    longint iw, ih, inter, uni;
    iw = span_overlap(longint'(a.x), longint'(a.w), longint'(b.x), longint'(b.w));
    ih = span_overlap(longint'(a.y), longint'(a.h), longint'(b.y), longint'(b.h));
    inter = iw * ih;
    uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
    if (uni <= 0) return 1'b0;
    return inter * 65536 > longint'(iou_thr) * uni;
  endfunction

  // absorb one detection; on last, sort, suppress and queue kept boxes
  task automatic predict_detection(in_t d);
    det_t t;
    bit   keep[$];
    int   n, kept, emitted;
    if (set_boxes.size() < MAX_BOXES) begin
      t.x = d.box_x; t.y = d.box_y; t.w = d.box_w; t.h = d.box_h;
      t.score = d.score; t.prob = d.obj_prob; t.cls = d.obj_class;
      set_boxes.push_back(t);
    end else begin
      set_dropped = 1'b1;
    end
    if (!d.last_in) return;
    n = set_boxes.size();
    for (int i = 0; i + 1 < n; i++)
      for (int j = i + 1; j < n; j++)
        if (set_boxes[j].score > set_boxes[i].score) begin
          t = set_boxes[i]; set_boxes[i] = set_boxes[j]; set_boxes[j] = t;
        end
    for (int i = 0; i < n; i++) keep.push_back(1'b1);
    for (int i = 0; i < n; i++) begin
      if (!keep[i]) continue;
      for (int j = i + 1; j < n; j++)
        if (keep[j] && set_boxes[i].cls == set_boxes[j].cls &&
            iou_above(set_boxes[i], set_boxes[j]))
          keep[j] = 1'b0;
    end
    kept = 0;
    foreach (keep[i]) if (keep[i]) kept++;
    emitted = 0;
    for (int i = 0; i < n; i++) begin
      out_t o;
      if (!keep[i]) continue;
      o.kept_x = set_boxes[i].x; o.kept_y = set_boxes[i].y;
      o.kept_w = set_boxes[i].w; o.kept_h = set_boxes[i].h;
      o.kept_score = set_boxes[i].score; o.kept_prob = set_boxes[i].prob;
      o.kept_class = set_boxes[i].cls;
      o.last_out = (emitted + 1 == kept);
      o.overflowed = set_dropped;
      kept_queue.push_back(o);
      emitted++;
    end
    set_boxes.delete();
    set_dropped = 1'b0;
  endtask

  // send one detection request, valid stays up into the next request
  task automatic send_detection(in_t d);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_detection(d);
    @(negedge clk);
  endtask

  function automatic in_t rand_detection(bit last, int cls_max);
    in_t d;
    d.box_x = 16'($urandom); d.box_y = 16'($urandom);
    d.box_w = 16'($urandom); d.box_h = 16'($urandom);
    d.score = 16'($urandom); d.obj_prob = 16'($urandom);
    d.obj_class = 5'($urandom_range(0, cls_max));
    d.last_in = last;
    return d;
  endfunction

  // clustered boxes so overlaps and suppressions are common
  function automatic in_t near_detection(bit last, int cls_max);
    in_t d;
    d = rand_detection(last, cls_max);
    d.box_x = 16'(16'h4000 + $urandom_range(0, 2047));
    d.box_y = 16'(16'h4000 + $urandom_range(0, 2047));
    d.box_w = 16'(16'h1000 + $urandom_range(0, 4095));
    d.box_h = 16'(16'h1000 + $urandom_range(0, 4095));
    if ($urandom_range(0, 3) == 0) d.score = 16'($urandom_range(0, 3));
    return d;
  endfunction

  // wait until the block has delivered all results, then settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (kept_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    iou_thr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (kept_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %p", out_data);
      end else begin
        out_t e;
        e = kept_queue.pop_front();
        if (out_data !== e) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // directed: extremes, zero sizes, ties, out of range class
  task automatic test_directed();
    in_t d;
    d = '0; d.last_in = 1'b1;
    send_detection(d);
    d = '1; d.obj_class = 5'd31; d.last_in = 1'b0;
    send_detection(d);
    d.last_in = 1'b1;
    send_detection(d);
    // identical boxes with equal scores, same class
    d = '0; d.box_x = 16'h1000; d.box_y = 16'h1000; d.box_w = 16'h0800;
    d.box_h = 16'h0800; d.score = 16'h8000; d.obj_prob = 16'h1234;
    d.obj_class = 5'd3;
    send_detection(d);
    d.obj_prob = 16'h5678;
    send_detection(d);
    d.obj_class = 5'd25; d.score = 16'hffff;
    send_detection(d);
    d.obj_class = 5'd3; d.score = 16'h0001; d.last_in = 1'b1;
    send_detection(d);
    for (int k = 0; k < 8; k++) send_detection(near_detection(k == 7, 1));
    drain_results();
  endtask

  // store full: drops and overflow flag
  task automatic test_overflow();
    for (int k = 0; k < MAX_BOXES + 3; k++)
      send_detection(rand_detection(k == MAX_BOXES + 2, 31));
    drain_results();
    for (int k = 0; k < MAX_BOXES + 1; k++)
      send_detection(near_detection(k == MAX_BOXES, 2));
    drain_results();
  endtask

  // random sets at several thresholds
  task automatic test_random_sets(logic [15:0] thr, int items);
    int sent;
    write_threshold(thr);
    sent = 0;
    while (sent < items) begin
      int len;
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 4) == 0) send_detection(rand_detection(k == len - 1, 31));
        else send_detection(near_detection(k == len - 1, 3));
      end
      sent += len;
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    iou_thr = THR_RESET;
    set_dropped = 1'b0;
    mismatch_count = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_overflow();
    test_random_sets(16'd0, 80);
    test_random_sets(16'hffff, 60);
    test_random_sets(16'h8000, 80);
    test_random_sets(16'd1, 40);
    idle_on = 1'b0;
    test_random_sets(THR_RESET, 60);
    if (mismatch_count == 0 && kept_queue.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: per_class_box_suppression.f
rtl/pcbs_pkg.sv
rtl/pcbs_iou.sv
rtl/pcbs_datapath.sv
rtl/pcbs_ctrl.sv
rtl/per_class_box_suppression.sv
test/per_class_box_suppression_tb.sv
